>>> sv/signed_int_to_decimal_ascii_macros.svh
// Assertion macros used by the top RTL file of the decimal text converter.
// Each check is an implication sampled on the rising clock edge and held off
// while reset is asserted.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define S2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2d assertion failed");

// Next-cycle implication.
`define S2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2d assertion failed");

`else

`define S2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define S2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/s2d_pkg.sv
`default_nettype none

package s2d_pkg;

    // Field widths and sizing of the converter.
    localparam int MAX_WIDTH   = 32;
    localparam int VALUE_W     = 32;
    localparam int MIN_WIDTH_W = 6;
    localparam int CHAR_W      = 6;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
    localparam int K_W         = $clog2(MAX_WIDTH);
    localparam int SHIFT_W     = $clog2(VALUE_W);
    localparam int NDIG_W      = $clog2(NUM_DIGITS + 1);
    localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);

    // Character codes.
    localparam logic [CHAR_W-1:0] CODE_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CODE_MINUS = CHAR_W'(45);

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic [MIN_WIDTH_W-1:0]     min_width;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } t_out_item;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_digit_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii.sv
// Flow: after an input transfer the value is shifted bit-serially through the digit
// chain, the field is sized, and the characters then leave through the output register.
// A new value is taken only once the last character of the previous one is out; each value
// gives N characters (1 to 32), one character per cycle while the receiver does not stall.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire s2d_pkg::t_in_item    i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output s2d_pkg::t_out_item        o_out
);
    import s2d_pkg::*;

    t_state                 r_state, n_state;
    logic                   r_neg, n_neg;
    logic [VALUE_W-1:0]     r_mag, n_mag;
    logic [CNT_W-1:0]       r_width, n_width;
    logic [SHIFT_W-1:0]     r_shift_cnt, n_shift_cnt;
    logic [K_W-1:0]         r_k, n_k;
    logic                   r_sign_pending, n_sign_pending;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    t_cell_ctrl             cell_ctrl;
    t_digit_row             digits;
    logic                   in_accept;
    logic                   out_load;
    logic [VALUE_W-1:0]     in_bits;
    logic [NDIG_W-1:0]      ndig;
    logic [CNT_W-1:0]       sign_ext;
    logic [CNT_W-1:0]       ndig_ext;
    logic [CNT_W-1:0]       rem;
    logic [CNT_W-1:0]       field;
    logic [DIGIT_W-1:0]     cur_digit;

    // Digit chain that turns the magnitude into decimal digits.
    s2d_chain u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (cell_ctrl),
        .i_bit    (r_mag[VALUE_W-1]),
        .o_digits (digits)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_load    = !r_out_valid || !i_out_stall;
    assign in_bits     = i_in.value;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Count of significant digits, at least one.
    always_comb begin
        ndig = NDIG_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (digits[i] != '0) begin
                ndig = NDIG_W'(i + 1);
            end
        end
    end

    // Field size: the width less the sign, but never fewer than the digits.
    always_comb begin
        sign_ext = CNT_W'(r_neg);
        ndig_ext = CNT_W'(ndig);
        rem      = r_width - sign_ext;
        field    = ((r_width > sign_ext) && (rem > ndig_ext)) ? rem : ndig_ext;
    end

    // Digit at the current position; positions above the chain read as zero.
    always_comb begin
        cur_digit = (r_k < K_W'(NUM_DIGITS)) ? digits[r_k[DIG_IDX_W-1:0]] : '0;
    end

    // Sequencer: accept, shift, size the field, then emit characters.
    always_comb begin
        n_state        = r_state;
        n_neg          = r_neg;
        n_mag          = r_mag;
        n_width        = r_width;
        n_shift_cnt    = r_shift_cnt;
        n_k            = r_k;
        n_sign_pending = r_sign_pending;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out          = r_out;
        cell_ctrl      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state     = ST_CONV;
                    n_neg       = in_bits[VALUE_W-1];
                    n_mag       = in_bits[VALUE_W-1] ? (~in_bits + 1'b1) : in_bits;
                    n_width     = (int'(i_in.min_width) > MAX_WIDTH) ?
                                  CNT_W'(MAX_WIDTH) : CNT_W'(i_in.min_width);
                    n_shift_cnt = SHIFT_W'(VALUE_W - 1);
                    cell_ctrl.clear = 1'b1;
                end
            end
            ST_CONV: begin
                cell_ctrl.shift = 1'b1;
                n_mag = {r_mag[VALUE_W-2:0], 1'b0};
                if (r_shift_cnt == '0) begin
                    n_state = ST_SIZE;
                end else begin
                    n_shift_cnt = r_shift_cnt - 1'b1;
                end
            end
            ST_SIZE: begin
                n_k            = K_W'(field - 1'b1);
                n_sign_pending = r_neg;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pending) begin
                        n_out.char_code = CODE_MINUS;
                        n_out.is_last   = 1'b0;
                        n_sign_pending  = 1'b0;
                    end else begin
                        n_out.char_code = CODE_ZERO + CHAR_W'(cur_digit);
                        n_out.is_last   = (r_k == '0);
                        if (r_k == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_k = r_k - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sign_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sign_pending <= n_sign_pending;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_width     <= n_width;
        r_shift_cnt <= n_shift_cnt;
        r_k         <= n_k;
        r_out       <= n_out;
    end

    // A transfer starts a full-length shift pass.
    `S2D_ASSERT_NXT(a_accept_starts_conv, i_clk, i_rst_n, in_accept, r_state == ST_CONV && r_shift_cnt == SHIFT_W'(VALUE_W - 1))
    // The chain holds decimal digits once the shift pass is done.
    `S2D_ASSERT_IMP(a_digit_decimal, i_clk, i_rst_n, r_state == ST_EMIT, cur_digit <= DIGIT_W'(9))
    // The sign is never the final character.
    `S2D_ASSERT_IMP(a_minus_not_last, i_clk, i_rst_n, r_out_valid && r_out.char_code == CODE_MINUS, !r_out.is_last)
    // No sign is left over once the sequencer is back to idle.
    `S2D_ASSERT_IMP(a_idle_no_sign, i_clk, i_rst_n, r_state == ST_IDLE, !r_sign_pending)

endmodule

`default_nettype wire

>>> sv/s2d_cell.sv
`default_nettype none

module s2d_cell (
    input  wire logic                     i_clk,
    input  wire s2d_pkg::t_cell_ctrl      i_ctrl,
    input  wire logic                     i_bit,
    output logic                          o_carry,
    output logic [s2d_pkg::DIGIT_W-1:0]   o_digit
);
    import s2d_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] adj;

    // Add three when the digit is five or more, so that the doubling carries
    // into the next decade.
    always_comb begin
        adj = (r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;
    end

    assign o_carry = adj[DIGIT_W-1];
    assign o_digit = r_digit;

    // Digit register: cleared at the start of a conversion, then shifted.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_digit <= {adj[DIGIT_W-2:0], i_bit};
        end
    end

endmodule

`default_nettype wire

>>> sv/s2d_chain.sv
`default_nettype none

module s2d_chain (
    input  wire logic                 i_clk,
    input  wire s2d_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic                 i_bit,
    output s2d_pkg::t_digit_row       o_digits
);
    import s2d_pkg::*;

    // Bit links between neighboring cells; link zero is the magnitude bit.
    logic [NUM_DIGITS:0] link;

    assign link[0] = i_bit;

    // One decimal digit per cell, least significant cell first.
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        s2d_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_bit   (link[g]),
            .o_carry (link[g+1]),
            .o_digit (o_digits[g])
        );
    end

endmodule

`default_nettype wire

>>> bench/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

    import s2d_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int PHASES       = 4;
    localparam int TAIL_CYCLES  = 80;

    // One row of the directed table: an empty text means the expected
    // characters come from the predictor.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [MIN_WIDTH_W-1:0]    min_width;
        logic [8*MAX_WIDTH-1:0]    text;
    } t_text_row;

    localparam int DIRECTED_ROWS = 21;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    t_out_item expected_chars[$];

    t_text_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{value: 32'sd0,           min_width: 6'd0,  text: "0"},
        '{value: 32'sd0,           min_width: 6'd1,  text: "0"},
        '{value: 32'sd0,           min_width: 6'd5,  text: "00000"},
        '{value: 32'sd7,           min_width: 6'd0,  text: "7"},
        '{value: -32'sd7,          min_width: 6'd0,  text: "-7"},
        '{value: -32'sd7,          min_width: 6'd3,  text: "-07"},
        '{value: -32'sd1,          min_width: 6'd1,  text: "-1"},
        '{value: 32'sh7fffffff,    min_width: 6'd0,  text: "2147483647"},
        '{value: 32'sh80000000,    min_width: 6'd0,  text: "-2147483648"},
        '{value: 32'sh80000000,    min_width: 6'd11, text: "-2147483648"},
        '{value: 32'sh80000000,    min_width: 6'd12, text: "-02147483648"},
        '{value: 32'sd42,          min_width: 6'd2,  text: "42"},
        '{value: 32'sd42,          min_width: 6'd3,  text: "042"},
        '{value: 32'sd1000000000,  min_width: 6'd10, text: "1000000000"},
        '{value: 32'sd999999999,   min_width: 6'd0,  text: "999999999"},
        '{value: -32'sd10,         min_width: 6'd2,  text: "-10"},
        '{value: 32'sh7fffffff,    min_width: 6'd32, text: '0},
        '{value: 32'sh80000000,    min_width: 6'd32, text: '0},
        '{value: 32'sd123,         min_width: 6'd63, text: '0},
        '{value: -32'sd5,          min_width: 6'd33, text: '0},
        '{value: 32'sd5,           min_width: 6'd32, text: '0}
    };

    signed_int_to_decimal_ascii uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    // 8 ns clock.
    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Queue the characters of a typed-in string, last one flagged.
    function automatic void push_text(input logic [8*MAX_WIDTH-1:0] text);
        t_out_item ch;
        for (int b = MAX_WIDTH - 1; b >= 0; b--) begin
            if (text[b*8 +: 8] != 8'd0) begin
                ch.char_code = text[b*8 +: CHAR_W];
                ch.is_last   = (b == 0);
                expected_chars.push_back(ch);
            end
        end
    endfunction

    // Work out the zero-padded decimal text of one value.
    function automatic void predict_decimal(input t_in_item item);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digit_of [0:NUM_DIGITS-1];
        int                 digit_count;
        int                 width;
        int                 sign_len;
        int                 pad_field;
        int                 char_total;
        int                 slot;
        t_out_item          ch;
        magnitude = item.value[VALUE_W-1] ? (~item.value + 1'b1) : item.value;
        sign_len  = item.value[VALUE_W-1] ? 1 : 0;
        // Peel digits off the unsigned magnitude, least significant first.
        digit_count = 0;
        do begin
            digit_of[digit_count] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            digit_count++;
        end while (magnitude != 0);
        width = (item.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(item.min_width);
        pad_field = width - sign_len;
        if (pad_field < digit_count) begin
            pad_field = digit_count;
        end
        char_total = sign_len + pad_field;
        slot = 0;
        if (sign_len != 0) begin
            ch.char_code = CODE_MINUS;
            ch.is_last   = (slot == char_total - 1);
            expected_chars.push_back(ch);
            slot++;
        end
        for (int k = pad_field - 1; k >= 0; k--) begin
            ch.char_code = CODE_ZERO + ((k < digit_count) ? CHAR_W'(digit_of[k]) : '0);
            ch.is_last   = (slot == char_total - 1);
            expected_chars.push_back(ch);
            slot++;
        end
    endfunction

    // Values weighted toward small magnitudes, powers of ten and the extremes.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int unsigned        pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: begin
                v = $urandom;
            end
            4, 5: begin
                v = $urandom_range(999);
            end
            6, 7: begin
                v = 1;
                repeat ($urandom_range(9)) v = v * 10;
                v = v + $urandom_range(2) - 1;
            end
            8: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v = $urandom_range(99999);
            end
        endcase
        if (pick != 8 && $urandom_range(1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // Present one value, hold it until the transfer, then predict its text.
    task automatic send_value(input t_in_item item, input logic [8*MAX_WIDTH-1:0] text);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = item;
        do @(posedge clk); while (in_stall);
        if (text != '0) begin
            push_text(text);
        end else begin
            predict_decimal(item);
        end
        @(negedge clk);
    endtask

    // Receiver back-pressure.
    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each character transfer with the oldest expectation.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                         $time, out_item.char_code, out_item.is_last);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                if (out_item.char_code !== want.char_code) begin
                    $display("%0t: char_code mismatch: expected %0d, actual %0d",
                             $time, want.char_code, out_item.char_code);
                    error_count++;
                end
                if (out_item.is_last !== want.is_last) begin
                    $display("%0t: is_last mismatch: expected %0b, actual %0b",
                             $time, want.is_last, out_item.is_last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random values over phases of sender idling and receiver stalls.
    initial begin
        t_in_item item;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            item.value     = directed_rows[r].value;
            item.min_width = directed_rows[r].min_width;
            send_value(item, directed_rows[r].text);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                item.value     = random_value();
                item.min_width = ($urandom_range(3) == 0) ? MIN_WIDTH_W'($urandom_range(63))
                                                          : MIN_WIDTH_W'($urandom_range(12));
                send_value(item, '0);
            end
        end
        in_valid = 1'b0;

        // Drain, then watch a while longer for stray characters.
        while (expected_chars.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0) begin
            $display("signed_int_to_decimal_ascii_test: clean");
        end else begin
            $display("signed_int_to_decimal_ascii_test: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("signed_int_to_decimal_ascii_test: errors");
        $finish;
    end

endmodule
